// File: hw/rtl/gcc_pkg.sv
// Package for the ground color classifier: rule codes, the HSV word passed
// between the front pipeline and the classifier stage, and fixed thresholds.
// Depends on nothing.
package gcc_pkg;

    localparam int unsigned ChanW = 8;
    localparam int unsigned HueW  = 17;

    typedef enum logic [2:0] {
        RULE_NONE  = 3'd0,
        RULE_VEG   = 3'd1,
        RULE_DARK  = 3'd2,
        RULE_GRAY  = 3'd3,
        RULE_EARTH = 3'd4
    } t_rule;

    typedef struct packed {
        logic sat_veg;
        logic sat_gray;
        logic sat_earth;
        logic val_veg;
        logic val_dark;
        logic val_gray;
        logic val_earth;
    } t_flags;

    typedef struct packed {
        logic [HueW-1:0]  hue_num;
        logic [ChanW-1:0] hue_den;
        t_flags           flags;
    } t_hsv;

    localparam logic [ChanW-1:0] ValVegMin   = 8'd52;
    localparam logic [ChanW-1:0] ValDarkMax  = 8'd40;
    localparam logic [ChanW-1:0] ValGrayMin  = 8'd46;
    localparam logic [ChanW-1:0] ValGrayMax  = 8'd216;
    localparam logic [ChanW-1:0] ValEarthMin = 8'd39;

    localparam logic [7:0] HueEarthLo = 8'd8;
    localparam logic [7:0] HueVegLo   = 8'd70;
    localparam logic [7:0] HueVegHi   = 8'd170;

endpackage

// File: hw/rtl/gcc_if.sv
// Handshake interfaces for the ground color classifier: the color word in
// and the classification word out. Depends on gcc_pkg.
interface gcc_pix_if;
    logic                     valid;
    logic                     ready;
    logic [gcc_pkg::ChanW-1:0] red;
    logic [gcc_pkg::ChanW-1:0] green;
    logic [gcc_pkg::ChanW-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface gcc_cls_if;
    logic       valid;
    logic       ready;
    logic       ground_like;
    logic [2:0] rule_hit;

    modport source (output valid, output ground_like, output rule_hit, input ready);
    modport sink (input valid, input ground_like, input rule_hit, output ready);
endinterface

// File: hw/rtl/gcc_hsv.sv
// Two-stage front pipeline: max, min and delta, then hue numerator and
// denominator with saturation and value threshold flags. Depends on gcc_pkg.
module gcc_hsv (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [gcc_pkg::ChanW-1:0] i_red,
    input  logic [gcc_pkg::ChanW-1:0] i_green,
    input  logic [gcc_pkg::ChanW-1:0] i_blue,
    output logic                      o_valid,
    input  logic                      i_ready,
    output gcc_pkg::t_hsv             o_hsv
);
    import gcc_pkg::*;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    logic               r_v1, r_v2;
    logic               w_adv1, w_adv2;
    logic [ChanW-1:0]   r_mx, n_mx;
    logic [ChanW-1:0]   r_d, n_d;
    logic signed [8:0]  r_diff, n_diff;
    t_sector            r_sec, n_sec;
    logic [ChanW-1:0]   w_mn;
    t_hsv               r_hsv, n_hsv;
    logic signed [17:0] w_h;
    logic [17:0]        w_d18;
    logic [17:0]        w_off;
    logic [10:0]        w_sd;

    assign w_adv2  = !r_v2 || i_ready;
    assign w_adv1  = !r_v1 || w_adv2;
    assign o_ready = w_adv1;
    assign o_valid = r_v2;
    assign o_hsv   = r_hsv;

    always_comb begin
        if (i_red >= i_green && i_red >= i_blue) begin
            n_sec  = SEC_RED;
            n_mx   = i_red;
            n_diff = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        end else if (i_green >= i_blue) begin
            n_sec  = SEC_GREEN;
            n_mx   = i_green;
            n_diff = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
        end else begin
            n_sec  = SEC_BLUE;
            n_mx   = i_blue;
            n_diff = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        end
        w_mn = i_red;
        if (i_green < w_mn) begin
            w_mn = i_green;
        end
        if (i_blue < w_mn) begin
            w_mn = i_blue;
        end
        n_d = n_mx - w_mn;
    end

    always_comb begin
        w_d18 = {10'd0, r_d};
        unique case (r_sec)
            SEC_GREEN: w_off = w_d18 * 18'd120;
            SEC_BLUE:  w_off = w_d18 * 18'd240;
            default:   w_off = 18'd0;
        endcase
        w_h = $signed({{9{r_diff[8]}}, r_diff}) * 18'sd60 + $signed(w_off);
        if (r_sec == SEC_RED && w_h < 18'sd0) begin
            w_h = w_h + $signed(w_d18 * 18'd360);
        end
        w_sd = (r_mx == '0) ? 11'd1 : {3'd0, r_mx};

        if (r_d == '0) begin
            n_hsv.hue_num = '0;
            n_hsv.hue_den = 8'd1;
        end else begin
            n_hsv.hue_num = w_h[HueW-1:0];
            n_hsv.hue_den = r_d;
        end
        n_hsv.flags.sat_veg   = (11'd5 * {3'd0, r_d}) > w_sd;
        n_hsv.flags.sat_gray  = (14'd50 * {6'd0, r_d}) < (14'd7 * {3'd0, w_sd});
        n_hsv.flags.sat_earth = (13'd25 * {5'd0, r_d}) >= (13'd3 * {2'd0, w_sd});
        n_hsv.flags.val_veg   = r_mx >= ValVegMin;
        n_hsv.flags.val_dark  = r_mx <= ValDarkMax;
        n_hsv.flags.val_gray  = r_mx >= ValGrayMin && r_mx <= ValGrayMax;
        n_hsv.flags.val_earth = r_mx >= ValEarthMin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= i_valid;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
        end
        if (w_adv1 && i_valid) begin
            r_mx   <= n_mx;
            r_d    <= n_d;
            r_diff <= n_diff;
            r_sec  <= n_sec;
        end
        if (w_adv2 && r_v1) begin
            r_hsv <= n_hsv;
        end
    end

endmodule

// File: hw/rtl/ground_color_classifier.sv
// Ground color classifier: RGB color word in, ground flag and deciding rule out.
// An accepted color passes the registered front stages and the registered rule stage to the output.
// Throughput is one word per cycle while the output is ready; each stage moves on when its successor
// is empty or moving, so a stall holds every word in place.
// Synchronous active-low reset empties all stages; the data registers are not reset.
// Depends on gcc_pkg, gcc_if and gcc_hsv.
module ground_color_classifier (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gcc_pix_if.sink   i_pix,
    gcc_cls_if.source o_cls
);
    import gcc_pkg::*;

    logic        w_hsv_valid;
    logic        w_hsv_ready;
    t_hsv        w_hsv;
    logic        r_v3;
    t_rule       r_rule, n_rule;
    logic        r_ground, n_ground;
    logic [16:0] w_k8, w_k70, w_k170;
    logic        w_hue_veg, w_hue_earth;

    gcc_hsv u_hsv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .o_ready (i_pix.ready),
        .i_red   (i_pix.red),
        .i_green (i_pix.green),
        .i_blue  (i_pix.blue),
        .o_valid (w_hsv_valid),
        .i_ready (w_hsv_ready),
        .o_hsv   (w_hsv)
    );

    assign w_hsv_ready = !r_v3 || o_cls.ready;

    always_comb begin
        w_k8   = {9'd0, w_hsv.hue_den} * {9'd0, HueEarthLo};
        w_k70  = {9'd0, w_hsv.hue_den} * {9'd0, HueVegLo};
        w_k170 = {9'd0, w_hsv.hue_den} * {9'd0, HueVegHi};
        w_hue_veg   = w_hsv.hue_num >= w_k70 && w_hsv.hue_num <= w_k170;
        w_hue_earth = w_hsv.hue_num >= w_k8 && w_hsv.hue_num <= w_k70;

        if (w_hue_veg && w_hsv.flags.sat_veg && w_hsv.flags.val_veg) begin
            n_rule = RULE_VEG;
        end else if (w_hsv.flags.val_dark) begin
            n_rule = RULE_DARK;
        end else if (w_hsv.flags.sat_gray && w_hsv.flags.val_gray) begin
            n_rule = RULE_GRAY;
        end else if (w_hue_earth && w_hsv.flags.sat_earth && w_hsv.flags.val_earth) begin
            n_rule = RULE_EARTH;
        end else begin
            n_rule = RULE_NONE;
        end
        n_ground = n_rule == RULE_DARK || n_rule == RULE_GRAY || n_rule == RULE_EARTH;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_hsv_ready) begin
            r_v3 <= w_hsv_valid;
        end
        if (w_hsv_ready && w_hsv_valid) begin
            r_rule   <= n_rule;
            r_ground <= n_ground;
        end
    end

    assign o_cls.valid       = r_v3;
    assign o_cls.ground_like = r_ground;
    assign o_cls.rule_hit    = r_rule;

endmodule

// File: hw/rtl/gcc_checker.sv
// Port-level checks for the ground color classifier, bound to its top level.
// Depends on gcc_pkg and ground_color_classifier.
module gcc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_ground_like,
    input logic [2:0] i_rule_hit
);
    import gcc_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Output word valid right after reset.");

    a_rule_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_rule_hit == RULE_NONE || i_rule_hit == RULE_VEG ||
                         i_rule_hit == RULE_DARK || i_rule_hit == RULE_GRAY ||
                         i_rule_hit == RULE_EARTH))
        else $error("Rule code out of range.");

    a_ground_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_ground_like == (i_rule_hit == RULE_DARK ||
                         i_rule_hit == RULE_GRAY || i_rule_hit == RULE_EARTH)))
        else $error("Ground flag disagrees with the deciding rule.");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("Input stalled while the output is not stalled.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_rule_hit) && $stable(i_ground_like)))
        else $error("Stalled output word changed.");

endmodule

bind ground_color_classifier gcc_checker u_gcc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_pix.valid),
    .i_in_ready    (i_pix.ready),
    .i_out_valid   (o_cls.valid),
    .i_out_ready   (o_cls.ready),
    .i_ground_like (o_cls.ground_like),
    .i_rule_hit    (o_cls.rule_hit)
);
